// File: rtl/block_convolver_unit_defines.svh
// Assertion macros for the checker file of the block convolver.
`ifndef BLOCK_CONVOLVER_UNIT_DEFINES_SVH
`define BLOCK_CONVOLVER_UNIT_DEFINES_SVH

// A property that is checked only outside of reset.
`define BCV_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// A property that is checked at every clock edge, reset included.
`define BCV_ASSERT_ALL(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error(msg);

`endif

// File: rtl/bcv_pkg.sv
`timescale 1ns / 1ps
package bcv_pkg;

    localparam int MAX_TAPS     = 64;
    localparam int KERNEL_DEPTH = 256;
    localparam int MAX_CHUNK    = 4096;
    localparam int SAMPLE_BITS  = 16;

    localparam int TAP_W      = $clog2(MAX_TAPS);
    localparam int KIDX_W     = $clog2(KERNEL_DEPTH);
    localparam int POS_W      = 12;
    localparam int OUT_POS_W  = 13;
    localparam int ACC_W      = 38;
    localparam int PROD_W     = 2 * SAMPLE_BITS;
    localparam int CHUNK_W    = 13;
    localparam int TAPS_W     = 7;
    localparam int KLEN_W     = 9;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    localparam logic OP_LOAD_COEF = 1'b0;
    localparam logic OP_SAMPLE    = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CHUNK_LEN  = 2'd0,
        CFG_TAPS       = 2'd1,
        CFG_KERNEL_LEN = 2'd2
    } t_cfg_index;

    typedef enum logic [2:0] {
        S_IDLE,
        S_REDUCE,
        S_ISSUE,
        S_DRAIN,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic clear;
        logic valid;
    } t_mac_ctl;

endpackage

// File: rtl/bcv_mac.sv
`timescale 1ns / 1ps
module bcv_mac (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  bcv_pkg::t_mac_ctl                      i_ctl,
    input  logic signed [bcv_pkg::SAMPLE_BITS-1:0] i_coef,
    input  logic signed [bcv_pkg::SAMPLE_BITS-1:0] i_sample,
    output logic signed [bcv_pkg::ACC_W-1:0]       o_acc,
    output logic                                   o_busy
);
    import bcv_pkg::*;

    logic signed [PROD_W-1:0] r_prod;
    logic                     r_prod_valid;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [ACC_W-1:0]  w_prod_ext;

    assign w_prod_ext = {{(ACC_W - PROD_W){r_prod[PROD_W-1]}}, r_prod};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_valid <= 1'b0;
        end else begin
            r_prod_valid <= i_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= i_coef * i_sample;
        if (i_ctl.clear) begin
            r_acc <= '0;
        end else if (r_prod_valid) begin
            r_acc <= r_acc + w_prod_ext;
        end
    end

    assign o_acc  = r_acc;
    assign o_busy = r_prod_valid;

endmodule

// File: rtl/bcv_mod.sv
`timescale 1ns / 1ps
module bcv_mod (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [bcv_pkg::KIDX_W-1:0]  i_dividend,
    input  logic [bcv_pkg::KLEN_W-1:0]  i_divisor,
    output logic                        o_done,
    output logic [bcv_pkg::KIDX_W-1:0]  o_rem
);
    import bcv_pkg::*;

    localparam int CNT_W = $clog2(KIDX_W);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [KIDX_W-1:0] r_num;
    logic [KIDX_W-1:0] r_rem;
    logic [KLEN_W-1:0] w_trial;
    logic [KLEN_W-1:0] w_diff;
    logic [KIDX_W-1:0] w_next;

    // One restoring step per cycle: shift in the next dividend bit and
    // subtract the divisor when it fits.
    always_comb begin
        w_trial = {r_rem, r_num[KIDX_W-1]};
        w_diff  = w_trial - i_divisor;
        if (w_trial >= i_divisor) begin
            w_next = w_diff[KIDX_W-1:0];
        end else begin
            w_next = w_trial[KIDX_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(KIDX_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_dividend;
            r_rem <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[KIDX_W-2:0], 1'b0};
            r_rem <= w_next;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

// File: rtl/block_convolver_unit.sv
`timescale 1ns / 1ps
// Coefficient load: writes the table, no result. Sample: the divider first reduces the table base,
// then for each result d (0, and 1..taps-1 after the last sample of a block) taps-d products
// are issued on the shared multiply-accumulate unit, followed by drain and output.
// The block is ready again once the last result is loaded.
// Synchronous active-low reset initialises control registers and block state but not the coefficient table.
module block_convolver_unit (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  logic                                   i_opcode,
    input  logic [bcv_pkg::KIDX_W-1:0]             i_coef_index,
    input  logic signed [bcv_pkg::SAMPLE_BITS-1:0] i_item_value,
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic signed [bcv_pkg::ACC_W-1:0]       o_result_value,
    output logic [bcv_pkg::OUT_POS_W-1:0]          o_out_position,
    output logic                                   o_last_of_run,
    output logic                                   o_end_of_block,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [bcv_pkg::CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [bcv_pkg::CFG_DATA_W-1:0]         i_cfg_data
);
    import bcv_pkg::*;

    t_state r_state;
    t_state n_state;

    logic [CHUNK_W-1:0] r_chunk_len;
    logic [TAPS_W-1:0]  r_taps_cfg;
    logic [KLEN_W-1:0]  r_klen_cfg;

    logic [POS_W-1:0]  r_pos;
    logic [KIDX_W-1:0] r_kbase;
    logic [TAP_W-1:0]  r_wptr;
    logic              r_block_end;
    logic [TAP_W-1:0]  r_d;
    logic [TAP_W-1:0]  r_j;
    logic [KIDX_W-1:0] r_dstart;
    logic [KIDX_W-1:0] r_cidx;

    logic signed [SAMPLE_BITS-1:0] r_coef_mem [KERNEL_DEPTH];
    logic signed [SAMPLE_BITS-1:0] r_hist_mem [MAX_TAPS];
    logic signed [SAMPLE_BITS-1:0] r_crd;
    logic signed [SAMPLE_BITS-1:0] r_hrd;
    logic                          r_rd_valid;
    logic                          r_rd_zero;

    logic                          r_out_valid;
    logic signed [ACC_W-1:0]       r_out_value;
    logic [OUT_POS_W-1:0]          r_out_pos;
    logic                          r_out_last;
    logic                          r_out_eob;

    logic [CHUNK_W-1:0] w_chunk;
    logic [TAPS_W-1:0]  w_taps;
    logic [KLEN_W-1:0]  w_klen;
    logic [TAP_W-1:0]   w_k;
    logic [TAP_W-1:0]   w_hist_addr;
    logic               w_hist_zero;
    logic [KIDX_W-1:0]  w_cidx_inc;
    logic [KIDX_W-1:0]  w_dstart_inc;
    logic               w_last_tap;
    logic               w_last_d;
    logic               w_last_run;
    logic               w_out_free;
    logic               w_in_xfer;
    logic               w_sample_xfer;
    logic               w_coef_xfer;
    logic               w_issue;
    logic               w_emit_load;
    logic               w_mod_start;
    logic               w_mod_done;
    logic [KIDX_W-1:0]  w_mod_rem;
    t_mac_ctl           w_mac_ctl;
    logic signed [SAMPLE_BITS-1:0] w_mac_sample;
    logic signed [ACC_W-1:0]       w_mac_acc;
    logic                          w_mac_busy;

    // Register values of zero act as one and oversized values saturate.
    always_comb begin
        if (r_chunk_len == '0) begin
            w_chunk = CHUNK_W'(1);
        end else if (r_chunk_len > CHUNK_W'(MAX_CHUNK)) begin
            w_chunk = CHUNK_W'(MAX_CHUNK);
        end else begin
            w_chunk = r_chunk_len;
        end
        if (r_taps_cfg == '0) begin
            w_taps = TAPS_W'(1);
        end else if (r_taps_cfg > TAPS_W'(MAX_TAPS)) begin
            w_taps = TAPS_W'(MAX_TAPS);
        end else begin
            w_taps = r_taps_cfg;
        end
        if (r_klen_cfg == '0) begin
            w_klen = KLEN_W'(1);
        end else if (r_klen_cfg > KLEN_W'(KERNEL_DEPTH)) begin
            w_klen = KLEN_W'(KERNEL_DEPTH);
        end else begin
            w_klen = r_klen_cfg;
        end
    end

    // The history is a circular buffer; samples older than the block start read as zero.
    assign w_k         = r_j - r_d;
    assign w_hist_addr = r_wptr - TAP_W'(1) - w_k;
    assign w_hist_zero = POS_W'(w_k) > r_pos;

    assign w_cidx_inc   = ((KLEN_W'(r_cidx) + KLEN_W'(1)) == w_klen) ?
                          '0 : r_cidx + KIDX_W'(1);
    assign w_dstart_inc = ((KLEN_W'(r_dstart) + KLEN_W'(1)) == w_klen) ?
                          '0 : r_dstart + KIDX_W'(1);

    assign w_last_tap = (TAPS_W'(r_j) + TAPS_W'(1)) == w_taps;
    assign w_last_d   = (TAPS_W'(r_d) + TAPS_W'(1)) == w_taps;
    assign w_last_run = !r_block_end || w_last_d;
    assign w_out_free = !r_out_valid || i_out_ready;

    assign w_in_xfer     = i_in_valid && o_in_ready;
    assign w_sample_xfer = w_in_xfer && (i_opcode == OP_SAMPLE);
    assign w_coef_xfer   = w_in_xfer && (i_opcode == OP_LOAD_COEF);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_sample_xfer) begin
                    n_state = S_REDUCE;
                end
            end
            S_REDUCE: begin
                if (w_mod_done) begin
                    n_state = S_ISSUE;
                end
            end
            S_ISSUE: begin
                if (w_last_tap) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!r_rd_valid && !w_mac_busy) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (w_out_free) begin
                    n_state = w_last_run ? S_IDLE : S_ISSUE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready      = (r_state == S_IDLE);
        w_mod_start     = w_sample_xfer;
        w_issue         = (r_state == S_ISSUE);
        w_emit_load     = (r_state == S_EMIT) && w_out_free;
        w_mac_ctl.clear = ((r_state == S_REDUCE) && w_mod_done) ||
                          (w_emit_load && !w_last_run);
        w_mac_ctl.valid = r_rd_valid;
    end

    assign w_mac_sample = r_rd_zero ? '0 : r_hrd;

    bcv_mod u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_mod_start),
        .i_dividend (r_kbase),
        .i_divisor  (w_klen),
        .o_done     (w_mod_done),
        .o_rem      (w_mod_rem)
    );

    bcv_mac u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_mac_ctl),
        .i_coef   (r_crd),
        .i_sample (w_mac_sample),
        .o_acc    (w_mac_acc),
        .o_busy   (w_mac_busy)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_chunk_len <= CHUNK_W'(256);
            r_taps_cfg  <= TAPS_W'(16);
            r_klen_cfg  <= KLEN_W'(16);
            r_pos       <= '0;
            r_kbase     <= '0;
            r_wptr      <= '0;
            r_block_end <= 1'b0;
            r_d         <= '0;
            r_j         <= '0;
            r_dstart    <= '0;
            r_cidx      <= '0;
            r_rd_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_rd_valid <= w_issue;

            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_CHUNK_LEN:  r_chunk_len <= i_cfg_data;
                    CFG_TAPS:       r_taps_cfg  <= i_cfg_data[TAPS_W-1:0];
                    CFG_KERNEL_LEN: r_klen_cfg  <= i_cfg_data[KLEN_W-1:0];
                    default: begin
                    end
                endcase
            end

            if (w_emit_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            if (w_sample_xfer) begin
                r_wptr      <= r_wptr + TAP_W'(1);
                r_block_end <= (CHUNK_W'(r_pos) + CHUNK_W'(1)) >= w_chunk;
                r_d         <= '0;
                r_j         <= '0;
            end

            if ((r_state == S_REDUCE) && w_mod_done) begin
                r_dstart <= w_mod_rem;
                r_cidx   <= w_mod_rem;
            end

            if (w_issue) begin
                r_j    <= r_j + TAP_W'(1);
                r_cidx <= w_cidx_inc;
            end

            if (w_emit_load) begin
                if (w_last_run) begin
                    if (r_block_end) begin
                        r_pos   <= '0;
                        r_kbase <= w_dstart_inc;
                    end else begin
                        r_pos <= r_pos + POS_W'(1);
                    end
                end else begin
                    r_d      <= r_d + TAP_W'(1);
                    r_j      <= r_d + TAP_W'(1);
                    r_dstart <= w_dstart_inc;
                    r_cidx   <= w_dstart_inc;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_coef_xfer) begin
            r_coef_mem[i_coef_index] <= i_item_value;
        end
        if (w_sample_xfer) begin
            r_hist_mem[r_wptr] <= i_item_value;
        end
        r_crd     <= r_coef_mem[r_cidx];
        r_hrd     <= r_hist_mem[w_hist_addr];
        r_rd_zero <= w_hist_zero;
        if (w_emit_load) begin
            r_out_value <= w_mac_acc;
            r_out_pos   <= OUT_POS_W'(r_pos) + OUT_POS_W'(r_d);
            r_out_last  <= w_last_run;
            r_out_eob   <= r_block_end && w_last_d;
        end
    end

    assign o_cfg_ready    = 1'b1;
    assign o_out_valid    = r_out_valid;
    assign o_result_value = r_out_value;
    assign o_out_position = r_out_pos;
    assign o_last_of_run  = r_out_last;
    assign o_end_of_block = r_out_eob;

endmodule

// File: rtl/bcv_checker.sv
`timescale 1ns / 1ps
`include "block_convolver_unit_defines.svh"
module bcv_checker (
    input logic                                   i_clk,
    input logic                                   i_rst_n,
    input logic                                   i_in_valid,
    input logic                                   o_in_ready,
    input logic                                   i_opcode,
    input logic [bcv_pkg::KIDX_W-1:0]             i_coef_index,
    input logic signed [bcv_pkg::SAMPLE_BITS-1:0] i_item_value,
    input logic                                   o_out_valid,
    input logic                                   i_out_ready,
    input logic signed [bcv_pkg::ACC_W-1:0]       o_result_value,
    input logic [bcv_pkg::OUT_POS_W-1:0]          o_out_position,
    input logic                                   o_last_of_run,
    input logic                                   o_end_of_block,
    input logic                                   i_cfg_valid,
    input logic                                   o_cfg_ready,
    input logic [bcv_pkg::CFG_IDX_W-1:0]          i_cfg_index,
    input logic [bcv_pkg::CFG_DATA_W-1:0]         i_cfg_data
);
    import bcv_pkg::*;

    // A result that is not taken stays offered.
    `BCV_ASSERT_RST(a_out_hold, o_out_valid && !i_out_ready |=> o_out_valid, "result dropped while stalled")

    // The final tail output of a block always closes its run.
    `BCV_ASSERT_RST(a_eob_last, o_out_valid && o_end_of_block |-> o_last_of_run, "end of block without last of run")

    // A sample transfer starts work, so the input side closes in the next cycle.
    `BCV_ASSERT_RST(a_busy_after_sample, i_in_valid && o_in_ready && (i_opcode == OP_SAMPLE) |=> !o_in_ready, "ready right after a sample")

    // While an earlier result of the run is pending, the run is not finished.
    `BCV_ASSERT_RST(a_run_open, o_out_valid && !o_last_of_run |-> !o_in_ready, "ready inside a run")

    // Reset leaves the block empty and ready.
    `BCV_ASSERT_ALL(a_reset_idle, !i_rst_n |=> !o_out_valid && o_in_ready, "reset did not idle the block")

endmodule

bind block_convolver_unit bcv_checker u_bcv_checker (.*);

// File: verif/block_convolver_unit_tb.sv
`timescale 1ns / 1ps
module block_convolver_unit_tb;
    import bcv_pkg::*;

    localparam int QUIET_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 16;
    localparam int HOLD_CYCLES   = 400;
    localparam int NUM_PHASES    = 12;

    typedef struct packed {
        logic signed [ACC_W-1:0] value;
        logic [OUT_POS_W-1:0]    pos;
        logic                    last;
        logic                    eob;
    } conv_result_t;

    typedef struct {
        bit                            is_cfg;
        t_cfg_index                    reg_sel;
        logic [CFG_DATA_W-1:0]         cfg_data;
        logic                          op;
        logic [KIDX_W-1:0]             idx;
        logic signed [SAMPLE_BITS-1:0] val;
        bit                            has_want;
        longint                        want_value;
    } stim_row_t;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_in_valid;
    logic                          o_in_ready;
    logic                          i_opcode;
    logic [KIDX_W-1:0]             i_coef_index;
    logic signed [SAMPLE_BITS-1:0] i_item_value;
    logic                          o_out_valid;
    logic                          i_out_ready;
    logic signed [ACC_W-1:0]       o_result_value;
    logic [OUT_POS_W-1:0]          o_out_position;
    logic                          o_last_of_run;
    logic                          o_end_of_block;
    logic                          i_cfg_valid;
    logic                          o_cfg_ready;
    logic [CFG_IDX_W-1:0]          i_cfg_index;
    logic [CFG_DATA_W-1:0]         i_cfg_data;

    block_convolver_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_opcode       (i_opcode),
        .i_coef_index   (i_coef_index),
        .i_item_value   (i_item_value),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_result_value (o_result_value),
        .o_out_position (o_out_position),
        .o_last_of_run  (o_last_of_run),
        .o_end_of_block (o_end_of_block),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    logic signed [SAMPLE_BITS-1:0] coef_tbl [KERNEL_DEPTH];
    logic signed [SAMPLE_BITS-1:0] sample_hist [MAX_TAPS];
    logic [POS_W-1:0]              blk_pos;
    int unsigned                   kern_base;
    int unsigned                   chunk_reg;
    int unsigned                   taps_reg;
    int unsigned                   klen_reg;

    conv_result_t pending_results [$];
    stim_row_t    dir_rows [$];

    int          tx_idle_pct;
    int          rx_stall_pct;
    bit          rx_hold;
    int unsigned quiet_cycles;
    int          errors;
    int          n_samples;
    int          n_loads;
    int          n_results;
    int          n_reg_writes;

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    function automatic int unsigned clamp_len(int unsigned v, int unsigned hi);
        if (v == 0) return 1;
        return (v > hi) ? hi : v;
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] rand_value();
        case ($urandom_range(0, 15))
            0: return SAMPLE_BITS'(-32768);
            1: return SAMPLE_BITS'(32767);
            2: return '0;
            3: return '1;
            default: return SAMPLE_BITS'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic stim_row_t cfg_row(t_cfg_index sel, int data);
        stim_row_t r;
        r = '{reg_sel: CFG_CHUNK_LEN, default: 0};
        r.is_cfg = 1'b1;
        r.reg_sel = sel;
        r.cfg_data = CFG_DATA_W'(data);
        return r;
    endfunction

    function automatic stim_row_t item_row(logic op, int idx, int val, bit has_want,
                                           longint want);
        stim_row_t r;
        r = '{reg_sel: CFG_CHUNK_LEN, default: 0};
        r.reg_sel = CFG_CHUNK_LEN;
        r.op = op;
        r.idx = KIDX_W'(idx);
        r.val = SAMPLE_BITS'(val);
        r.has_want = has_want;
        r.want_value = want;
        return r;
    endfunction

    // Updates the table, or shifts the sample in and queues the outputs it completes.
    function automatic void convolve_item(logic op, logic [KIDX_W-1:0] idx,
                                          logic signed [SAMPLE_BITS-1:0] val);
        int unsigned  chunk;
        int unsigned  taps;
        int unsigned  klen;
        int unsigned  runs;
        int unsigned  d;
        int unsigned  j;
        int           i;
        bit           blk_end;
        longint       acc;
        conv_result_t r;
        if (op == OP_LOAD_COEF) begin
            coef_tbl[idx] = val;
            n_loads++;
            return;
        end
        n_samples++;
        chunk = clamp_len(chunk_reg, MAX_CHUNK);
        taps = clamp_len(taps_reg, MAX_TAPS);
        klen = clamp_len(klen_reg, KERNEL_DEPTH);
        if (blk_pos == '0) begin
            for (i = 0; i < MAX_TAPS; i++) sample_hist[i] = '0;
        end
        for (i = MAX_TAPS - 1; i > 0; i--) sample_hist[i] = sample_hist[i-1];
        sample_hist[0] = val;
        blk_end = (32'(blk_pos) + 1 >= chunk);
        runs = blk_end ? taps : 1;
        for (d = 0; d < runs; d++) begin
            acc = 0;
            for (j = d; j < taps; j++) begin
                acc += longint'(sample_hist[j-d]) *
                       longint'(coef_tbl[(kern_base + j) % klen]);
            end
            r.value = acc[ACC_W-1:0];
            r.pos = OUT_POS_W'(blk_pos) + OUT_POS_W'(d);
            r.last = !blk_end || (d + 1 == taps);
            r.eob = blk_end && (d + 1 == taps);
            pending_results.push_back(r);
        end
        if (blk_end) begin
            blk_pos = '0;
            kern_base = (kern_base + taps) % klen;
        end else begin
            blk_pos = blk_pos + 1'b1;
        end
    endfunction

    task automatic send_item(input logic op, input logic [KIDX_W-1:0] idx,
                             input logic signed [SAMPLE_BITS-1:0] val);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_opcode = op;
        i_coef_index = idx;
        i_item_value = val;
        do @(posedge i_clk); while (!o_in_ready);
        convolve_item(op, idx, val);
    endtask

    task automatic drain_results(input bit settle);
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        if (settle) repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_index sel, input logic [CFG_DATA_W-1:0] data);
        drain_results(1'b1);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = sel;
        i_cfg_data = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (sel)
            CFG_CHUNK_LEN:  chunk_reg = 32'(data);
            CFG_TAPS:       taps_reg = 32'(data[TAPS_W-1:0]);
            CFG_KERNEL_LEN: klen_reg = 32'(data[KLEN_W-1:0]);
            default: ;
        endcase
        n_reg_writes++;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic run_items(input int count, input int pause_at);
        int k;
        for (k = 0; k < count; k++) begin
            if (k == pause_at) drain_results(1'b0);
            send_item(($urandom_range(0, 99) < 15) ? OP_LOAD_COEF : OP_SAMPLE,
                      KIDX_W'($urandom_range(0, 255)), rand_value());
        end
    endtask

    always @(negedge i_clk) begin
        i_out_ready = !rx_hold && ($urandom_range(0, 99) >= rx_stall_pct);
    end

    always @(posedge i_clk) begin : check_results
        conv_result_t want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            n_results++;
            if (pending_results.size() == 0) begin
                errors++;
                if (errors <= 20)
                    $display("%0t: unexpected result value %0d position %0d last %0b eob %0b",
                             $time, o_result_value, o_out_position, o_last_of_run,
                             o_end_of_block);
            end else begin
                want = pending_results.pop_front();
                if (want.value !== o_result_value || want.pos !== o_out_position ||
                    want.last !== o_last_of_run || want.eob !== o_end_of_block) begin
                    errors++;
                    if (errors <= 20)
                        $display("%0t: expected %0d/%0d/%0b/%0b got %0d/%0d/%0b/%0b",
                                 $time, want.value, want.pos, want.last, want.eob,
                                 o_result_value, o_out_position, o_last_of_run,
                                 o_end_of_block);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("block_convolver_unit: mismatch");
            $finish;
        end
    end

    initial begin
        int                    ph;
        int                    k;
        int                    n_items;
        logic [CFG_DATA_W-1:0] chunk_d;
        logic [CFG_DATA_W-1:0] taps_d;
        logic [CFG_DATA_W-1:0] klen_d;
        conv_result_t          r;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_opcode = 1'b0;
        i_coef_index = '0;
        i_item_value = '0;
        i_out_ready = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        tx_idle_pct = 0;
        rx_stall_pct = 0;
        rx_hold = 1'b0;
        quiet_cycles = 0;
        errors = 0;
        n_samples = 0;
        n_loads = 0;
        n_results = 0;
        n_reg_writes = 0;
        for (k = 0; k < MAX_TAPS; k++) sample_hist[k] = '0;
        blk_pos = '0;
        kern_base = 0;
        chunk_reg = 256;
        taps_reg = 16;
        klen_reg = 16;

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // The table survives reset without a defined value, so every entry is written first.
        for (k = 0; k < KERNEL_DEPTH; k++) send_item(OP_LOAD_COEF, KIDX_W'(k), rand_value());

        dir_rows.push_back(cfg_row(CFG_TAPS, 1));
        dir_rows.push_back(cfg_row(CFG_CHUNK_LEN, 1));
        dir_rows.push_back(cfg_row(CFG_KERNEL_LEN, 1));
        dir_rows.push_back(item_row(OP_LOAD_COEF, 0, -32768, 0, 0));
        dir_rows.push_back(item_row(OP_SAMPLE, 0, -32768, 1, 1073741824));
        dir_rows.push_back(item_row(OP_SAMPLE, 0, 32767, 1, -1073709056));
        dir_rows.push_back(item_row(OP_LOAD_COEF, 0, 32767, 0, 0));
        dir_rows.push_back(item_row(OP_SAMPLE, 0, 32767, 1, 1073676289));
        dir_rows.push_back(item_row(OP_SAMPLE, 255, 0, 1, 0));
        dir_rows.push_back(item_row(OP_LOAD_COEF, 255, -1, 0, 0));
        dir_rows.push_back(cfg_row(CFG_TAPS, 0));
        dir_rows.push_back(cfg_row(CFG_CHUNK_LEN, 0));
        dir_rows.push_back(cfg_row(CFG_KERNEL_LEN, 0));
        dir_rows.push_back(item_row(OP_SAMPLE, 0, -1, 1, -32767));
        dir_rows.push_back(cfg_row(CFG_TAPS, 127));
        dir_rows.push_back(cfg_row(CFG_CHUNK_LEN, 8191));
        dir_rows.push_back(cfg_row(CFG_KERNEL_LEN, 511));
        dir_rows.push_back(item_row(OP_SAMPLE, 0, 32767, 1, 1073676289));
        dir_rows.push_back(item_row(OP_SAMPLE, 0, -32768, 0, 0));
        dir_rows.push_back(item_row(OP_SAMPLE, 0, 12345, 0, 0));
        dir_rows.push_back(cfg_row(CFG_KERNEL_LEN, 5));
        dir_rows.push_back(item_row(OP_SAMPLE, 0, -20000, 0, 0));
        dir_rows.push_back(cfg_row(CFG_TAPS, 4));
        dir_rows.push_back(cfg_row(CFG_CHUNK_LEN, 2));
        dir_rows.push_back(item_row(OP_SAMPLE, 0, 777, 0, 0));
        dir_rows.push_back(item_row(OP_SAMPLE, 0, 1, 0, 0));
        dir_rows.push_back(cfg_row(CFG_TAPS, 1));
        dir_rows.push_back(item_row(OP_SAMPLE, 0, -5, 0, 0));
        dir_rows.push_back(item_row(OP_LOAD_COEF, 200, 32767, 0, 0));

        foreach (dir_rows[row]) begin
            if (dir_rows[row].is_cfg) begin
                write_reg(dir_rows[row].reg_sel, dir_rows[row].cfg_data);
            end else begin
                send_item(dir_rows[row].op, dir_rows[row].idx, dir_rows[row].val);
                if (dir_rows[row].has_want) begin
                    r = pending_results.pop_back();
                    r.value = ACC_W'(dir_rows[row].want_value);
                    pending_results.push_back(r);
                end
            end
        end

        for (ph = 0; ph < NUM_PHASES; ph++) begin
            n_items = 8;
            chunk_d = CFG_DATA_W'($urandom_range(1, 6));
            taps_d = CFG_DATA_W'($urandom_range(1, 10));
            klen_d = CFG_DATA_W'($urandom_range(1, 256));
            if ($urandom_range(0, 3) == 0)
                taps_d = taps_d | CFG_DATA_W'($urandom_range(1, 63) << TAPS_W);
            if ($urandom_range(0, 3) == 0)
                klen_d = klen_d | CFG_DATA_W'($urandom_range(1, 15) << KLEN_W);
            case (ph)
                2: begin
                    chunk_d = '0;
                    taps_d = '0;
                    klen_d = '0;
                end
                5: begin
                    chunk_d = CFG_DATA_W'(2);
                    taps_d = CFG_DATA_W'(MAX_TAPS);
                    klen_d = CFG_DATA_W'(KERNEL_DEPTH);
                    n_items = 8;
                end
                8: begin
                    chunk_d = '1;
                    taps_d = '1;
                    klen_d = '1;
                end
                default: ;
            endcase
            write_reg(CFG_CHUNK_LEN, chunk_d);
            write_reg(CFG_TAPS, taps_d);
            write_reg(CFG_KERNEL_LEN, klen_d);
            tx_idle_pct = (ph % 4 == 1) ? 46 : ((ph % 4 == 3) ? 14 : 0);
            rx_stall_pct = (ph % 4 == 2) ? 46 : ((ph % 4 == 3) ? 14 : 0);
            if (ph == 6) begin
                // The output side stays blocked long enough for the input to back up.
                fork
                    begin
                        rx_hold = 1'b1;
                        repeat (HOLD_CYCLES) @(posedge i_clk);
                        rx_hold = 1'b0;
                    end
                    run_items(n_items, -1);
                join
            end else begin
                run_items(n_items, (ph == 9) ? n_items / 2 : -1);
            end
        end

        drain_results(1'b1);
        $display("Checked %0d results from %0d samples and %0d coefficient loads,",
                 n_results, n_samples, n_loads);
        $display("%0d register writes; idling ran none, sender, receiver and both, with a hold.",
                 n_reg_writes);
        if (errors == 0) begin
            $display("block_convolver_unit: match");
        end else begin
            $display("block_convolver_unit: mismatch");
        end
        $finish;
    end

endmodule

// File: block_convolver_unit.f
+incdir+rtl
rtl/bcv_pkg.sv
rtl/bcv_mac.sv
rtl/bcv_mod.sv
rtl/block_convolver_unit.sv
rtl/bcv_checker.sv
verif/block_convolver_unit_tb.sv
